// File: hdl/midi_to_link_byte_translator_core_defines.svh
// Assertion macros for the MIDI to link byte translator.
// Included by modules that carry concurrent checks; expects clock and reset in scope.
`ifndef MIDI_TO_LINK_BYTE_TRANSLATOR_CORE_DEFINES_SVH
`define MIDI_TO_LINK_BYTE_TRANSLATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a property on the rising clock edge, disabled while rst is high
`define MLBT_ASSERT_ON(lbl, rst, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (rst) prop) else $error(msg);

// Check a property, disabled while the block reset is high
`define MLBT_ASSERT(lbl, prop, msg) \
   `MLBT_ASSERT_ON(lbl, reset, prop, msg)

`else

`define MLBT_ASSERT_ON(lbl, rst, prop, msg)
`define MLBT_ASSERT(lbl, prop, msg)

`endif

`endif

// File: hdl/mlbt_pkg.sv
// Shared types, codes and lookup functions for the MIDI to link byte translator.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package mlbt_pkg;

   // Mode register codes
   localparam logic [2:0] MODE_CLOCK_SYNC  = 3'd0;
   localparam logic [2:0] MODE_CLOCK_SLAVE = 3'd1;
   localparam logic [2:0] MODE_ROW_MAP     = 3'd2;
   localparam logic [2:0] MODE_KEYBOARD    = 3'd3;
   localparam logic [2:0] MODE_PASSTHROUGH = 3'd4;

   // Input action codes
   localparam logic [1:0] ACT_MIDI    = 2'd0;
   localparam logic [1:0] ACT_STARTED = 2'd1;
   localparam logic [1:0] ACT_STOPPED = 2'd2;

   // MIDI status high nibbles
   localparam logic [3:0] HI_NOTE_OFF = 4'h8;
   localparam logic [3:0] HI_NOTE_ON  = 4'h9;

   // Link bytes
   localparam logic [7:0] BYTE_OCT_UP     = 8'h06;
   localparam logic [7:0] BYTE_OCT_DOWN   = 8'h05;
   localparam logic [7:0] BYTE_EXT_PREFIX = 8'hE0;
   localparam logic [7:0] BYTE_ROW_OFF    = 8'hFE;
   localparam logic [7:0] BYTE_START      = 8'hFA;
   localparam logic [7:0] BYTE_STOP       = 8'hFC;

   // Note thresholds
   localparam logic [7:0] KEY_NOTE_START  = 8'd48;
   localparam logic [7:0] LOW_NOTE_START  = 8'd36;
   localparam logic [7:0] SECOND_ROW_BASE = 8'h3C;
   localparam logic [7:0] NOTE_BYTE_BASE  = 8'd30;
   localparam logic [7:0] NOTE_PLAY       = 8'd24;
   localparam logic [7:0] NOTE_HALT       = 8'd25;
   localparam logic [7:0] NOTE_DIV1       = 8'd26;
   localparam logic [7:0] NOTE_DIV2       = 8'd27;
   localparam logic [7:0] NOTE_DIV4       = 8'd28;
   localparam logic [7:0] NOTE_DIV8       = 8'd29;
   localparam logic [2:0] OCTAVE_MAX      = 3'd6;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_LOAD,
      ST_SEND
   } mlbt_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;
      logic decode;
      logic load;
   } mlbt_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic pending;
   } mlbt_sts_type;

   // Remainder by twelve through a reciprocal multiply (exact for 0..255)
   function automatic logic [3:0] mod12(input logic [7:0] v);
      logic [15:0] prod;
      logic [4:0]  quot;
      logic [7:0]  rem;
      prod = {8'd0, v} * 16'd171;
      quot = prod[15:11];
      rem  = v - ({3'd0, quot} * 8'd12);
      return rem[3:0];
   endfunction

   // Keyboard scancode for a note within two rows of twelve
   function automatic logic [7:0] scan_code(input logic [4:0] idx);
      logic [7:0] code;
      case (idx)
         5'd0:  code = 8'h1A;
         5'd1:  code = 8'h1B;
         5'd2:  code = 8'h22;
         5'd3:  code = 8'h23;
         5'd4:  code = 8'h21;
         5'd5:  code = 8'h2A;
         5'd6:  code = 8'h34;
         5'd7:  code = 8'h32;
         5'd8:  code = 8'h33;
         5'd9:  code = 8'h31;
         5'd10: code = 8'h3B;
         5'd11: code = 8'h3A;
         5'd12: code = 8'h15;
         5'd13: code = 8'h1E;
         5'd14: code = 8'h1D;
         5'd15: code = 8'h26;
         5'd16: code = 8'h24;
         5'd17: code = 8'h2D;
         5'd18: code = 8'h2E;
         5'd19: code = 8'h2C;
         5'd20: code = 8'h36;
         5'd21: code = 8'h35;
         5'd22: code = 8'h3D;
         5'd23: code = 8'h3C;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

   // Command key for the low note range
   function automatic logic [7:0] low_code(input logic [3:0] idx);
      logic [7:0] code;
      case (idx)
         4'd0:  code = 8'h01;
         4'd1:  code = 8'h09;
         4'd2:  code = 8'h78;
         4'd3:  code = 8'h07;
         4'd4:  code = 8'h68;
         4'd5:  code = 8'h74;
         4'd6:  code = 8'h75;
         4'd7:  code = 8'h72;
         4'd8:  code = 8'h5A;
         4'd9:  code = 8'h7A;
         4'd10: code = 8'h7D;
         4'd11: code = 8'h29;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

// File: hdl/mlbt_ctrl.sv
// Controller state machine for the MIDI to link byte translator.
// Depends on mlbt_pkg and the assertion macro header.
`default_nettype none
`include "midi_to_link_byte_translator_core_defines.svh"

module mlbt_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire mlbt_pkg::mlbt_sts_type sts,
   output mlbt_pkg::mlbt_cmd_type     cmd
);
   import mlbt_pkg::*;

   mlbt_state_type state_ff, state_in;

   // Hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Advance the state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = sts.pending ? ST_SEND : ST_IDLE;
         end
         ST_SEND: begin
            if (rsp_ready && !sts.pending) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Drive handshakes and datapath commands; take no input while in reset
   always_comb begin
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.capture = 1'b0;
      cmd.decode  = 1'b0;
      cmd.load    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = !reset;
            cmd.capture = req_valid && !reset;
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
         end
         ST_LOAD: begin
            cmd.load = sts.pending;
         end
         ST_SEND: begin
            rsp_valid = 1'b1;
            cmd.load  = rsp_ready && sts.pending;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   `MLBT_ASSERT(a_no_overlap, !(req_ready && rsp_valid), "input taken while a byte is shown")
   `MLBT_ASSERT(a_accept_decode, (req_valid && req_ready) |=> (state_ff == ST_DECODE), "accepted item not decoded next")
   `MLBT_ASSERT(a_load_pending, cmd.load |-> sts.pending, "byte loaded with nothing pending")

endmodule

`default_nettype wire

// File: hdl/mlbt_datapath.sv
// Datapath for the MIDI to link byte translator: input capture, mode state,
// byte plan and output register. Depends on mlbt_pkg and the assertion macro header.
`default_nettype none
`include "midi_to_link_byte_translator_core_defines.svh"

module mlbt_datapath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire mlbt_pkg::mlbt_cmd_type cmd,
   output mlbt_pkg::mlbt_sts_type      sts,
   input  wire logic                   csr_wr_en,
   input  wire logic [2:0]             csr_wr_data,
   input  wire logic [1:0]             req_action,
   input  wire logic [7:0]             req_status_byte,
   input  wire logic [7:0]             req_first_data,
   input  wire logic [7:0]             req_second_data,
   input  wire logic [15:0]            req_frame_offset,
   output logic [7:0]                  rsp_link_byte,
   output logic [15:0]                 rsp_byte_offset,
   output logic                        rsp_last_byte,
   output logic                        rsp_clock_enabled,
   output logic [3:0]                  rsp_tempo_divide
);
   import mlbt_pkg::*;

   // Captured input item
   logic [1:0]  action_ff;
   logic [7:0]  status_ff;
   logic [7:0]  data1_ff;
   logic [7:0]  data2_ff;
   logic [15:0] offset_ff;

   // Mode register and persistent state
   logic [2:0] mode_ff, mode_in;
   logic [2:0] octave_ff, octave_in;
   logic [7:0] held_row_ff, held_row_in;
   logic       held_valid_ff, held_valid_in;
   logic       play_ff, play_in;
   logic [3:0] div_ff, div_in;

   // Byte plan: octave steps first, then up to three main bytes
   logic [2:0]  step_cnt_ff, step_cnt_in;
   logic [7:0]  step_code_ff, step_code_in;
   logic [1:0]  main_cnt_ff, main_cnt_in;
   logic [7:0]  main0_ff, main0_in;
   logic [7:0]  main1_ff, main1_in;
   logic [7:0]  main2_ff, main2_in;
   logic [15:0] main_off_ff, main_off_in;

   // Output register
   logic [7:0]  out_byte_ff, out_byte_in;
   logic [15:0] out_off_ff, out_off_in;
   logic        out_last_ff, out_last_in;

   // Decoder results
   logic [2:0]  d_steps;
   logic [7:0]  d_code;
   logic [1:0]  d_cnt;
   logic [7:0]  d_b0, d_b1, d_b2;
   logic [15:0] d_off;
   logic [2:0]  d_octave;
   logic [7:0]  d_held_row;
   logic        d_held_valid;
   logic        d_play;
   logic [3:0]  d_div;

   // Capture the input item on transfer
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_action;
         status_ff <= req_status_byte;
         data1_ff  <= req_first_data;
         data2_ff  <= req_second_data;
         offset_ff <= req_frame_offset;
      end
   end

   // Decode the captured item into a byte plan and next state
   always_comb begin
      logic [3:0] hi;
      logic [3:0] chan;
      logic [7:0] rel;
      logic [7:0] row;
      logic [7:0] lcmd;
      logic [7:0] lidx;
      logic [4:0] sidx;
      logic [3:0] rmod;
      logic [2:0] oct;

      hi   = status_ff[7:4];
      chan = status_ff[3:0];
      rel  = data1_ff - KEY_NOTE_START;
      lidx = data1_ff - LOW_NOTE_START;
      lcmd = low_code(lidx[3:0]);
      row  = {data1_ff[7] ^ chan[0], data1_ff[6:0]};
      rmod = mod12(rel);
      sidx = (rel >= SECOND_ROW_BASE) ? ({1'b0, rmod} + 5'd12) : {1'b0, rmod};

      // Octave from the note, capped
      if (rel >= 8'd72) begin
         oct = OCTAVE_MAX;
      end else if (rel >= 8'd60) begin
         oct = 3'd5;
      end else if (rel >= 8'd48) begin
         oct = 3'd4;
      end else if (rel >= 8'd36) begin
         oct = 3'd3;
      end else if (rel >= 8'd24) begin
         oct = 3'd2;
      end else if (rel >= 8'd12) begin
         oct = 3'd1;
      end else begin
         oct = 3'd0;
      end

      d_steps      = 3'd0;
      d_code       = BYTE_OCT_UP;
      d_cnt        = 2'd0;
      d_b0         = 8'h00;
      d_b1         = 8'h00;
      d_b2         = 8'h00;
      d_off        = offset_ff;
      d_octave     = octave_ff;
      d_held_row   = held_row_ff;
      d_held_valid = held_valid_ff;
      d_play       = play_ff;
      d_div        = div_ff;

      if (action_ff == ACT_STARTED || action_ff == ACT_STOPPED) begin
         // Transport bytes go out only in clock-slave mode
         if (mode_ff == MODE_CLOCK_SLAVE) begin
            d_cnt = 2'd1;
            d_b0  = (action_ff == ACT_STARTED) ? BYTE_START : BYTE_STOP;
            d_off = 16'd0;
         end
      end else if (action_ff == ACT_MIDI) begin
         case (mode_ff)
            MODE_CLOCK_SLAVE: begin
               if (hi == HI_NOTE_ON) begin
                  if (data1_ff == NOTE_PLAY) begin
                     d_play = 1'b1;
                  end else if (data1_ff == NOTE_HALT) begin
                     d_play = 1'b0;
                  end else if (data1_ff == NOTE_DIV1) begin
                     d_div = 4'd1;
                  end else if (data1_ff == NOTE_DIV2) begin
                     d_div = 4'd2;
                  end else if (data1_ff == NOTE_DIV4) begin
                     d_div = 4'd4;
                  end else if (data1_ff == NOTE_DIV8) begin
                     d_div = 4'd8;
                  end else if (data1_ff >= NOTE_BYTE_BASE) begin
                     d_cnt = 2'd1;
                     d_b0  = data1_ff - NOTE_BYTE_BASE;
                  end
               end
            end
            MODE_ROW_MAP: begin
               if (chan <= 4'd1) begin
                  if (hi == HI_NOTE_ON) begin
                     d_cnt        = 2'd1;
                     d_b0         = row;
                     d_held_row   = row;
                     d_held_valid = 1'b1;
                  end else if (hi == HI_NOTE_OFF) begin
                     if (held_valid_ff && held_row_ff == row) begin
                        d_cnt        = 2'd1;
                        d_b0         = BYTE_ROW_OFF;
                        d_held_valid = 1'b0;
                     end
                  end
               end
            end
            MODE_KEYBOARD: begin
               if (hi == HI_NOTE_ON) begin
                  if (data1_ff >= KEY_NOTE_START) begin
                     // Step the octave, then send the scancode
                     if (oct > octave_ff) begin
                        d_steps = oct - octave_ff;
                        d_code  = BYTE_OCT_UP;
                     end else begin
                        d_steps = octave_ff - oct;
                        d_code  = BYTE_OCT_DOWN;
                     end
                     d_octave = oct;
                     d_cnt    = 2'd1;
                     d_b0     = scan_code(sidx);
                  end else if (data1_ff >= LOW_NOTE_START) begin
                     // Cursor keys carry the extended prefix
                     if (lcmd == 8'h68 || lcmd == 8'h72 || lcmd == 8'h74 || lcmd == 8'h75) begin
                        d_cnt = 2'd2;
                        d_b0  = BYTE_EXT_PREFIX;
                        d_b1  = lcmd;
                     end else begin
                        d_cnt = 2'd1;
                        d_b0  = lcmd;
                     end
                  end
               end
            end
            MODE_PASSTHROUGH: begin
               d_cnt = 2'd3;
               d_b0  = status_ff;
               d_b1  = data1_ff;
               d_b2  = data2_ff;
            end
            default: begin
               d_cnt = 2'd0;
            end
         endcase
      end
   end

   // Select the next value of state, plan and output register
   always_comb begin
      mode_in       = csr_wr_en ? csr_wr_data : mode_ff;
      octave_in     = octave_ff;
      held_row_in   = held_row_ff;
      held_valid_in = held_valid_ff;
      play_in       = play_ff;
      div_in        = div_ff;
      step_cnt_in   = step_cnt_ff;
      step_code_in  = step_code_ff;
      main_cnt_in   = main_cnt_ff;
      main0_in      = main0_ff;
      main1_in      = main1_ff;
      main2_in      = main2_ff;
      main_off_in   = main_off_ff;
      out_byte_in   = out_byte_ff;
      out_off_in    = out_off_ff;
      out_last_in   = out_last_ff;

      if (cmd.decode) begin
         octave_in     = d_octave;
         held_row_in   = d_held_row;
         held_valid_in = d_held_valid;
         play_in       = d_play;
         div_in        = d_div;
         step_cnt_in   = d_steps;
         step_code_in  = d_code;
         main_cnt_in   = d_cnt;
         main0_in      = d_b0;
         main1_in      = d_b1;
         main2_in      = d_b2;
         main_off_in   = d_off;
      end else if (cmd.load) begin
         if (step_cnt_ff != 3'd0) begin
            // Pop an octave step
            out_byte_in = step_code_ff;
            out_off_in  = 16'd0;
            out_last_in = (step_cnt_ff == 3'd1) && (main_cnt_ff == 2'd0);
            step_cnt_in = step_cnt_ff - 3'd1;
         end else begin
            // Pop a main byte and shift the rest down
            out_byte_in = main0_ff;
            out_off_in  = main_off_ff;
            out_last_in = (main_cnt_ff == 2'd1);
            main_cnt_in = main_cnt_ff - 2'd1;
            main0_in    = main1_ff;
            main1_in    = main2_ff;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_CLOCK_SYNC;
         octave_ff     <= 3'd0;
         held_row_ff   <= 8'd0;
         held_valid_ff <= 1'b0;
         play_ff       <= 1'b0;
         div_ff        <= 4'd1;
         step_cnt_ff   <= 3'd0;
         main_cnt_ff   <= 2'd0;
      end else begin
         mode_ff       <= mode_in;
         octave_ff     <= octave_in;
         held_row_ff   <= held_row_in;
         held_valid_ff <= held_valid_in;
         play_ff       <= play_in;
         div_ff        <= div_in;
         step_cnt_ff   <= step_cnt_in;
         main_cnt_ff   <= main_cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      step_code_ff <= step_code_in;
      main0_ff     <= main0_in;
      main1_ff     <= main1_in;
      main2_ff     <= main2_in;
      main_off_ff  <= main_off_in;
      out_byte_ff  <= out_byte_in;
      out_off_ff   <= out_off_in;
      out_last_ff  <= out_last_in;
   end

   assign sts.pending       = (step_cnt_ff != 3'd0) || (main_cnt_ff != 2'd0);
   assign rsp_link_byte     = out_byte_ff;
   assign rsp_byte_offset   = out_off_ff;
   assign rsp_last_byte     = out_last_ff;
   assign rsp_clock_enabled = play_ff;
   assign rsp_tempo_divide  = div_ff;

   `MLBT_ASSERT(a_div_onehot, $onehot(div_ff), "tempo divisor not a power of two")
   `MLBT_ASSERT(a_octave_cap, octave_ff <= OCTAVE_MAX, "octave beyond cap")
   `MLBT_ASSERT(a_step_zero_off, (cmd.load && step_cnt_ff != 3'd0) |=> (out_off_ff == 16'd0 && !out_last_ff), "octave step byte with offset or end mark")

endmodule

`default_nettype wire

// File: hdl/midi_to_link_byte_translator_core.sv
// MIDI to link byte translator, top level: controller plus datapath.
// Depends on mlbt_pkg, mlbt_ctrl and mlbt_datapath.
//
// Usage:
//   req_* channel carries one MIDI message or transport event per transfer;
//   rsp_* channel returns zero to seven link bytes for it, in order, with
//   rsp_last_byte set on the final one. An item that makes no byte returns
//   nothing. csr_wr_en/csr_wr_data write the mode register; write only while
//   the block is idle.
//   One item at a time: req_ready is high only in the idle state. After the
//   input transfer the item passes through a decode state and a load state,
//   then each byte is shown in the send state until rsp_ready takes it.
//   A stall on rsp_ready holds the current byte and its fields unchanged and
//   holds off further input.
//   Reset (synchronous, active high) returns to idle, clears the mode to
//   clock sync, octave, held row and play flag, and sets the divisor to one.
`default_nettype none

module midi_to_link_byte_translator_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_action,
   input  wire logic [7:0]  req_status_byte,
   input  wire logic [7:0]  req_first_data,
   input  wire logic [7:0]  req_second_data,
   input  wire logic [15:0] req_frame_offset,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_link_byte,
   output logic [15:0]      rsp_byte_offset,
   output logic             rsp_last_byte,
   output logic             rsp_clock_enabled,
   output logic [3:0]       rsp_tempo_divide
);
   import mlbt_pkg::*;

   mlbt_cmd_type cmd;
   mlbt_sts_type sts;

   // Sequence the item through decode and byte delivery
   mlbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Hold state, plan bytes and drive the result payload
   mlbt_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_action        (req_action),
      .req_status_byte   (req_status_byte),
      .req_first_data    (req_first_data),
      .req_second_data   (req_second_data),
      .req_frame_offset  (req_frame_offset),
      .rsp_link_byte     (rsp_link_byte),
      .rsp_byte_offset   (rsp_byte_offset),
      .rsp_last_byte     (rsp_last_byte),
      .rsp_clock_enabled (rsp_clock_enabled),
      .rsp_tempo_divide  (rsp_tempo_divide)
   );

endmodule

`default_nettype wire
